### src/ile_pkg.sv
// shared types and constants for the indexed list engine
`timescale 1ns / 1ps
package ile_pkg;

  localparam int DATA_W       = 32;
  localparam int FUNC_W       = 3;
  localparam int POS_W        = 7;
  localparam int LEN_W        = 7;
  localparam int STATUS_W     = 2;
  localparam int CAPACITY_DEF = 64;

  // operation codes
  localparam logic [FUNC_W-1:0] OP_GET  = 3'd0;
  localparam logic [FUNC_W-1:0] OP_HEAD = 3'd1;
  localparam logic [FUNC_W-1:0] OP_TAIL = 3'd2;
  localparam logic [FUNC_W-1:0] OP_AT   = 3'd3;
  localparam logic [FUNC_W-1:0] OP_DEL  = 3'd4;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  localparam logic [DATA_W-1:0] ALL_ONES = '1;

  // step applied to operand a by the index unit
  typedef enum logic [1:0] {
    DELTA_ZERO = 2'd0,
    DELTA_INC  = 2'd1,
    DELTA_DEC  = 2'd2
  } delta_t;

  // compare flags of the index unit: (a + delta) against b
  typedef struct packed {
    logic lt;
    logic eq;
  } alu_flags_t;

endpackage

### src/ile_ram.sv
// generic single write port, single read port ram with registered read
`timescale 1ns / 1ps
module ile_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/ile_alu.sv
// shared index unit: step an index by -1, 0 or +1 and compare it
`timescale 1ns / 1ps
module ile_alu #(
  parameter int W = 7
) (
  input  logic [W-1:0]        a,
  input  logic [W-1:0]        b,
  input  ile_pkg::delta_t     delta,
  output logic [W-1:0]        sum,
  output ile_pkg::alu_flags_t flags
);

  import ile_pkg::*;

  always_comb begin
    unique case (delta)
      DELTA_INC: sum = a + W'(1);
      DELTA_DEC: sum = a - W'(1);
      default:   sum = a;
    endcase
    flags.lt = (sum < b);
    flags.eq = (sum == b);
  end

endmodule

### src/indexed_list_engine.sv
// indexed list engine top level: sequencer, element ram and shared index unit
//
// bounded ordered list of signed 32-bit values, at most CAPACITY elements.
// command channel: an item (func, position, item_value) is taken at a rising
// edge with start high and busy low. busy stays high while the item is
// worked on; the next item may be started in the cycle its result shows.
// result channel: done is high for exactly one cycle with read_value, status
// and length; the receiver cannot stall it, so nothing waits on it.
// a get issues its ram read in decode and reports the registered data; any item
// ignored or dropped finishes from decode. an insert at slot p (head p = 0,
// tail p = n, n = length before) moves each element from slot idx - 1 up to
// slot idx, then writes the value; a delete at slot p moves each element
// above p down one slot. the element ram has one read port and one write
// port, so each moved element takes a read state and a write state, with
// the shared index unit stepping and testing the loop index.
// reset clears the held count to zero and returns the sequencer to idle; the
// ram contents are not cleared, since slots past the length are never read.
// length is reported modulo 128 when CAPACITY is above 127.
`timescale 1ns / 1ps
module indexed_list_engine #(
  parameter int CAPACITY = ile_pkg::CAPACITY_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [ile_pkg::FUNC_W-1:0]        func,
  input  logic [ile_pkg::POS_W-1:0]         position,
  input  logic signed [ile_pkg::DATA_W-1:0] item_value,
  output logic                              done,
  output logic signed [ile_pkg::DATA_W-1:0] read_value,
  output logic [ile_pkg::STATUS_W-1:0]      status,
  output logic [ile_pkg::LEN_W-1:0]         length
);

  import ile_pkg::*;

  // ram address width and index width (index must hold both position
  // and the full count)
  localparam int AW = $clog2(CAPACITY);
  localparam int CW = ($clog2(CAPACITY + 1) > POS_W) ? $clog2(CAPACITY + 1) : POS_W;

  typedef enum logic [9:0] {
    S_IDLE     = 10'b0000000001,
    S_DECODE   = 10'b0000000010,
    S_GET_WAIT = 10'b0000000100,
    S_INS_TEST = 10'b0000001000,
    S_INS_RD   = 10'b0000010000,
    S_INS_WR   = 10'b0000100000,
    S_INS_PUT  = 10'b0001000000,
    S_DEL_RD   = 10'b0010000000,
    S_DEL_WR   = 10'b0100000000,
    S_DEL_FIN  = 10'b1000000000
  } state_t;

  state_t state, state_next;

  // control state
  logic [CW-1:0] count, count_next;
  logic          done_next;

  // captured item and loop registers
  logic [FUNC_W-1:0]   func_q, func_q_next;
  logic [CW-1:0]       pos_q, pos_q_next;
  logic [DATA_W-1:0]   val_q, val_q_next;
  logic [CW-1:0]       idx, idx_next;    // moving loop index
  logic [AW-1:0]       dst, dst_next;    // slot the pending read lands in
  logic [CW-1:0]       tpos, tpos_next;  // insert slot

  // result registers
  logic [DATA_W-1:0]   read_value_next;
  logic [STATUS_W-1:0] status_next;
  logic [LEN_W-1:0]    length_next;

  // ram ports
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [DATA_W-1:0] ram_rdata;

  // shared index unit ports
  logic [CW-1:0] alu_a, alu_b, alu_sum;
  delta_t        alu_delta;
  alu_flags_t    alu_flags;

  logic full;

  assign full = (count == CW'(CAPACITY));
  assign busy = (state != S_IDLE);

  ile_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  ile_alu #(
    .W (CW)
  ) u_alu (
    .a     (alu_a),
    .b     (alu_b),
    .delta (alu_delta),
    .sum   (alu_sum),
    .flags (alu_flags)
  );

  // operand selection for the shared index unit
  always_comb begin
    alu_a     = pos_q;
    alu_b     = count;
    alu_delta = DELTA_ZERO;
    unique case (state)
      S_INS_TEST, S_INS_WR: begin
        // keep shifting while the insert slot is below the index
        alu_a = tpos;
        alu_b = idx;
      end
      S_INS_RD: begin
        alu_a     = idx;
        alu_delta = DELTA_DEC;
      end
      S_INS_PUT: begin
        alu_a     = count;
        alu_delta = DELTA_INC;
      end
      S_DEL_RD: begin
        // next source slot idx + 1, still inside the list?
        alu_a     = idx;
        alu_delta = DELTA_INC;
      end
      S_DEL_FIN: begin
        alu_a     = count;
        alu_delta = DELTA_DEC;
      end
      default: begin
        // decode compares position against the length
        alu_a = pos_q;
        alu_b = count;
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_next      = state;
    count_next      = count;
    done_next       = 1'b0;
    func_q_next     = func_q;
    pos_q_next      = pos_q;
    val_q_next      = val_q;
    idx_next        = idx;
    dst_next        = dst;
    tpos_next       = tpos;
    read_value_next = read_value;
    status_next     = status;
    length_next     = length;
    ram_we          = 1'b0;
    ram_waddr       = dst;
    ram_wdata       = ram_rdata;
    ram_raddr       = pos_q[AW-1:0];

    unique case (state)
      S_IDLE: begin
        if (start) begin
          func_q_next = func;
          pos_q_next  = CW'(position);
          val_q_next  = item_value;
          state_next  = S_DECODE;
        end
      end

      S_DECODE: begin
        // default outcome: finish at once with no change
        read_value_next = ALL_ONES;
        status_next     = ST_DONE;
        length_next     = count[LEN_W-1:0];
        idx_next        = count;
        case (func_q)
          OP_GET: begin
            if (alu_flags.lt) begin
              // read issued at pos_q this cycle
              state_next = S_GET_WAIT;
            end else begin
              status_next = ST_RANGE;
              done_next   = 1'b1;
              state_next  = S_IDLE;
            end
          end
          OP_HEAD, OP_TAIL: begin
            if (full) begin
              status_next = ST_FULL;
              done_next   = 1'b1;
              state_next  = S_IDLE;
            end else begin
              tpos_next  = (func_q == OP_HEAD) ? '0 : count;
              state_next = S_INS_TEST;
            end
          end
          OP_AT: begin
            if (!alu_flags.lt && !alu_flags.eq) begin
              // past the end: range check wins over full
              status_next = ST_RANGE;
              done_next   = 1'b1;
              state_next  = S_IDLE;
            end else if (full) begin
              status_next = ST_FULL;
              done_next   = 1'b1;
              state_next  = S_IDLE;
            end else begin
              tpos_next  = pos_q;
              state_next = S_INS_TEST;
            end
          end
          OP_DEL: begin
            if (alu_flags.lt) begin
              idx_next   = pos_q;
              state_next = S_DEL_RD;
            end else begin
              status_next = ST_RANGE;
              done_next   = 1'b1;
              state_next  = S_IDLE;
            end
          end
          default: begin
            // unknown operation changes nothing
            done_next  = 1'b1;
            state_next = S_IDLE;
          end
        endcase
      end

      S_GET_WAIT: begin
        read_value_next = ram_rdata;
        status_next     = ST_DONE;
        length_next     = count[LEN_W-1:0];
        done_next       = 1'b1;
        state_next      = S_IDLE;
      end

      S_INS_TEST: begin
        state_next = alu_flags.lt ? S_INS_RD : S_INS_PUT;
      end

      S_INS_RD: begin
        // move slot idx - 1 up to slot idx
        ram_raddr  = alu_sum[AW-1:0];
        dst_next   = idx[AW-1:0];
        idx_next   = alu_sum;
        state_next = S_INS_WR;
      end

      S_INS_WR: begin
        ram_we     = 1'b1;
        ram_waddr  = dst;
        ram_wdata  = ram_rdata;
        state_next = alu_flags.lt ? S_INS_RD : S_INS_PUT;
      end

      S_INS_PUT: begin
        ram_we      = 1'b1;
        ram_waddr   = tpos[AW-1:0];
        ram_wdata   = val_q;
        count_next  = alu_sum;
        length_next = alu_sum[LEN_W-1:0];
        done_next   = 1'b1;
        state_next  = S_IDLE;
      end

      S_DEL_RD: begin
        if (alu_flags.lt) begin
          // move slot idx + 1 down to slot idx
          ram_raddr  = alu_sum[AW-1:0];
          dst_next   = idx[AW-1:0];
          idx_next   = alu_sum;
          state_next = S_DEL_WR;
        end else begin
          state_next = S_DEL_FIN;
        end
      end

      S_DEL_WR: begin
        ram_we     = 1'b1;
        ram_waddr  = dst;
        ram_wdata  = ram_rdata;
        state_next = S_DEL_RD;
      end

      S_DEL_FIN: begin
        count_next  = alu_sum;
        length_next = alu_sum[LEN_W-1:0];
        done_next   = 1'b1;
        state_next  = S_IDLE;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= done_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    func_q     <= func_q_next;
    pos_q      <= pos_q_next;
    val_q      <= val_q_next;
    idx        <= idx_next;
    dst        <= dst_next;
    tpos       <= tpos_next;
    read_value <= read_value_next;
    status     <= status_next;
    length     <= length_next;
  end

  // a result only shows once the sequencer is back in idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> (state == S_IDLE))
    else $error("result strobe outside idle");

  // reported length matches the held count
  a_done_len: assert property (@(posedge clk) disable iff (rst)
    done |-> (length == count[LEN_W-1:0]))
    else $error("reported length differs from count");

  // an accepted item always enters decode
  a_accept: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (state == S_DECODE))
    else $error("accepted item not decoded");

  // a dropped insert only happens on a full list
  a_full: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_FULL) |-> (count == CW'(CAPACITY)))
    else $error("full status with room left");

  // the count only moves at the end of an insert or a delete
  a_count: assert property (@(posedge clk) disable iff (rst)
    (count != $past(count)) |->
      ($past(state) == S_INS_PUT || $past(state) == S_DEL_FIN))
    else $error("count changed outside insert or delete");

endmodule

### tb/sv/tb_indexed_list_engine.sv
// self-checking testbench for the indexed list engine: directed table, then random phases
`timescale 1ns / 1ps
module tb_indexed_list_engine;
  import ile_pkg::*;

  // spare operation codes, the block must leave the list alone for these
  localparam logic [FUNC_W-1:0] OP_SPARE_A = 3'd5;
  localparam logic [FUNC_W-1:0] OP_SPARE_B = 3'd6;
  localparam logic [FUNC_W-1:0] OP_SPARE_C = 3'd7;

  localparam int CAPACITY   = CAPACITY_DEF;
  localparam int MAX_LAT    = 2 * CAPACITY + 8;   // longest insert plus margin
  localparam int PHASE_ITEMS = 250;

  // one result as the block reports it
  typedef struct {
    logic [DATA_W-1:0]   rd;
    logic [STATUS_W-1:0] st;
    logic [LEN_W-1:0]    len;
  } list_result_t;

  // one row of the directed table; typed rows carry a hand-written expectation
  typedef struct {
    logic [FUNC_W-1:0]   f;
    logic [POS_W-1:0]    p;
    logic [DATA_W-1:0]   v;
    bit                  typed;
    list_result_t        res;
  } script_row_t;

  // random mix of operations, picked in runs so the list both fills and empties
  typedef enum {MIX_GROW, MIX_SHRINK, MIX_CHURN} op_mix_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     start = 1'b0;
  logic                     busy;
  logic [FUNC_W-1:0]        func = '0;
  logic [POS_W-1:0]         position = '0;
  logic signed [DATA_W-1:0] item_value = '0;
  logic                     done;
  logic signed [DATA_W-1:0] read_value;
  logic [STATUS_W-1:0]      status;
  logic [LEN_W-1:0]         length;

  logic [DATA_W-1:0] list_shadow[$];       // predicted list contents, head first
  list_result_t      pending_results[$];   // expectations in item order
  script_row_t       script[$];
  int                mismatches = 0;
  int                idle_pct = 0;         // chance in a hundred of a gap before an item

  indexed_list_engine dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .func       (func),
    .position   (position),
    .item_value (item_value),
    .done       (done),
    .read_value (read_value),
    .status     (status),
    .length     (length)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // hard stop in case the block hangs
  initial begin
    #10_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  task automatic flag_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t ns: %s", $time, msg);
    end
  endtask

  // list behavior: apply one operation to the shadow list, return its result
  function automatic list_result_t apply_list_op(logic [FUNC_W-1:0] f, logic [POS_W-1:0] p,
                                                 logic [DATA_W-1:0] v);
    list_result_t r;
    int           n;
    bit           full;
    n = list_shadow.size();
    full = n >= CAPACITY;
    r.rd = ALL_ONES;
    r.st = ST_DONE;
    case (f)
      OP_GET: begin
        if (int'(p) < n) r.rd = list_shadow[p];
        else r.st = ST_RANGE;
      end
      OP_HEAD: begin
        if (full) r.st = ST_FULL;
        else list_shadow.push_front(v);
      end
      OP_TAIL: begin
        if (full) r.st = ST_FULL;
        else list_shadow.push_back(v);
      end
      OP_AT: begin
        // range check wins over the full check
        if (int'(p) > n) r.st = ST_RANGE;
        else if (full) r.st = ST_FULL;
        else list_shadow.insert(p, v);
      end
      OP_DEL: begin
        if (int'(p) < n) list_shadow.delete(p);
        else r.st = ST_RANGE;
      end
      default: ;
    endcase
    r.len = LEN_W'(list_shadow.size());
    return r;
  endfunction

  // drive one item at the falling edge, hold it until taken, then record what should come back
  task automatic issue_item(logic [FUNC_W-1:0] f, logic [POS_W-1:0] p, logic [DATA_W-1:0] v,
                            bit typed, list_result_t typed_res);
    list_result_t predicted;
    int           gap;
    gap = ($urandom_range(99) < idle_pct) ? $urandom_range(1, 8) : 0;
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start      <= 1'b1;
    func       <= f;
    position   <= p;
    item_value <= v;
    // taken at the first rising edge that sees busy low
    do @(posedge clk); while (busy !== 1'b0);
    predicted = apply_list_op(f, p, v);
    pending_results.push_back(typed ? typed_res : predicted);
  endtask

  // sender goes quiet until every outstanding result is back
  task automatic wait_for_results();
    int guard;
    guard = 0;
    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0 && guard < 4 * MAX_LAT) begin
      @(posedge clk);
      guard++;
    end
  endtask

  function automatic void add_row(logic [FUNC_W-1:0] f, logic [POS_W-1:0] p,
                                  logic [DATA_W-1:0] v, bit typed, logic [DATA_W-1:0] rd,
                                  logic [STATUS_W-1:0] st, logic [LEN_W-1:0] len);
    script_row_t row;
    row.f = f;
    row.p = p;
    row.v = v;
    row.typed = typed;
    row.res.rd = rd;
    row.res.st = st;
    row.res.len = len;
    script.push_back(row);
  endfunction

  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(9))
      0: return '0;
      1: return ALL_ONES;
      2: return 32'h7fff_ffff;
      3: return 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  // mostly valid positions, some at the boundary and some anywhere in the field
  function automatic logic [POS_W-1:0] pick_position(logic [FUNC_W-1:0] f);
    int n;
    int s;
    n = list_shadow.size();
    s = $urandom_range(99);
    if (s < 15) return POS_W'($urandom_range(127));
    if (s < 25) return POS_W'(n);
    if (f == OP_AT) return POS_W'($urandom_range(n));
    return (n > 0) ? POS_W'($urandom_range(n - 1)) : '0;
  endfunction

  task automatic run_random(int count);
    op_mix_t           mix;
    int                run_left;
    int                w;
    int                cut[5];
    logic [FUNC_W-1:0] f;
    list_result_t      none;
    none = '{default: '0};
    run_left = 0;
    mix = MIX_CHURN;
    for (int i = 0; i < count; i++) begin
      if (run_left == 0) begin
        mix = op_mix_t'($urandom_range(2));
        run_left = $urandom_range(20, 70);
      end
      run_left--;
      // cumulative weights: get, head, tail, at, delete, then spare codes
      case (mix)
        MIX_GROW:   cut = '{10, 35, 60, 88, 96};
        MIX_SHRINK: cut = '{15, 25, 35, 45, 96};
        default:    cut = '{30, 45, 60, 75, 96};
      endcase
      w = $urandom_range(99);
      if (w < cut[0]) f = OP_GET;
      else if (w < cut[1]) f = OP_HEAD;
      else if (w < cut[2]) f = OP_TAIL;
      else if (w < cut[3]) f = OP_AT;
      else if (w < cut[4]) f = OP_DEL;
      else f = FUNC_W'($urandom_range(OP_SPARE_C, OP_SPARE_A));
      issue_item(f, pick_position(f), pick_value(), 1'b0, none);
    end
  endtask

  // result checker: every strobe must match the oldest expectation
  always @(posedge clk) begin : check_results
    list_result_t want;
    if (!rst && done === 1'b1) begin
      if (pending_results.size() == 0) begin
        flag_mismatch($sformatf(
          "result with nothing outstanding: read_value %h status %0d length %0d",
          read_value, status, length));
      end else begin
        want = pending_results.pop_front();
        if (read_value !== want.rd)
          flag_mismatch($sformatf("read_value expected %h got %h", want.rd, read_value));
        if (status !== want.st)
          flag_mismatch($sformatf("status expected %0d got %0d", want.st, status));
        if (length !== want.len)
          flag_mismatch($sformatf("length expected %0d got %0d", want.len, length));
      end
    end
  end

  initial begin : stimulus
    list_result_t none;
    logic [FUNC_W-1:0] f;
    int pct[3];
    none = '{default: '0};
    pct = '{0, 73, 11};

    // directed table: empty list, extremes of values and positions, every range case
    add_row(OP_GET,     7'd0,   32'd0,        1, ALL_ONES,     ST_RANGE, 7'd0);
    add_row(OP_DEL,     7'd0,   32'd0,        1, ALL_ONES,     ST_RANGE, 7'd0);
    add_row(OP_AT,      7'd1,   32'd5,        1, ALL_ONES,     ST_RANGE, 7'd0);
    add_row(OP_AT,      7'd0,   32'h7fffffff, 1, ALL_ONES,     ST_DONE,  7'd1);
    add_row(OP_HEAD,    7'd0,   32'h80000000, 1, ALL_ONES,     ST_DONE,  7'd2);
    add_row(OP_TAIL,    7'd127, 32'd0,        1, ALL_ONES,     ST_DONE,  7'd3);
    add_row(OP_GET,     7'd0,   32'hffffffff, 1, 32'h80000000, ST_DONE,  7'd3);
    add_row(OP_GET,     7'd1,   32'd0,        1, 32'h7fffffff, ST_DONE,  7'd3);
    add_row(OP_GET,     7'd2,   32'd0,        1, 32'd0,        ST_DONE,  7'd3);
    // insert at the length appends
    add_row(OP_AT,      7'd3,   32'hffffffff, 1, ALL_ONES,     ST_DONE,  7'd4);
    add_row(OP_GET,     7'd3,   32'd0,        1, 32'hffffffff, ST_DONE,  7'd4);
    add_row(OP_GET,     7'd4,   32'd0,        1, ALL_ONES,     ST_RANGE, 7'd4);
    add_row(OP_AT,      7'd127, 32'd1,        1, ALL_ONES,     ST_RANGE, 7'd4);
    add_row(OP_AT,      7'd5,   32'd1,        1, ALL_ONES,     ST_RANGE, 7'd4);
    add_row(OP_GET,     7'd127, 32'd0,        1, ALL_ONES,     ST_RANGE, 7'd4);
    add_row(OP_DEL,     7'd127, 32'd0,        1, ALL_ONES,     ST_RANGE, 7'd4);
    add_row(OP_DEL,     7'd4,   32'd0,        1, ALL_ONES,     ST_RANGE, 7'd4);
    // spare codes do nothing
    add_row(OP_SPARE_A, 7'd0,   32'd99,       1, ALL_ONES,     ST_DONE,  7'd4);
    add_row(OP_SPARE_C, 7'd127, 32'hffffffff, 1, ALL_ONES,     ST_DONE,  7'd4);
    add_row(OP_SPARE_B, 7'd64,  32'd0,        1, ALL_ONES,     ST_DONE,  7'd4);
    // shifting cases, checked against the predictor
    add_row(OP_AT,      7'd1,   32'h5a5a5a5a, 0, '0, '0, '0);
    add_row(OP_DEL,     7'd0,   32'd0,        0, '0, '0, '0);
    add_row(OP_GET,     7'd1,   32'd0,        0, '0, '0, '0);
    add_row(OP_DEL,     7'd3,   32'd0,        0, '0, '0, '0);
    add_row(OP_HEAD,    7'd0,   32'h12345678, 0, '0, '0, '0);

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (script[i]) begin
      issue_item(script[i].f, script[i].p, script[i].v, script[i].typed, script[i].res);
    end
    wait_for_results();

    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = pct[ph];
      if (ph == 0) begin
        // fill to capacity with random inserts, then hit the full cases
        while (list_shadow.size() < CAPACITY) begin
          f = FUNC_W'($urandom_range(OP_AT, OP_HEAD));
          issue_item(f, POS_W'($urandom_range(list_shadow.size())), pick_value(), 1'b0, none);
        end
        issue_item(OP_HEAD, 7'd0, pick_value(), 1'b0, none);
        issue_item(OP_TAIL, 7'd0, pick_value(), 1'b0, none);
        issue_item(OP_AT, POS_W'(CAPACITY), pick_value(), 1'b0, none);
        issue_item(OP_AT, POS_W'(CAPACITY + 1), pick_value(), 1'b0, none);
        issue_item(OP_AT, 7'd0, pick_value(), 1'b0, none);
        issue_item(OP_GET, POS_W'(CAPACITY - 1), 32'd0, 1'b0, none);
        issue_item(OP_GET, POS_W'(CAPACITY), 32'd0, 1'b0, none);
        issue_item(OP_DEL, POS_W'(CAPACITY - 1), 32'd0, 1'b0, none);
        issue_item(OP_DEL, 7'd0, 32'd0, 1'b0, none);
      end
      run_random(PHASE_ITEMS);
      wait_for_results();
    end

    // quiet tail to catch any stray strobe
    repeat (MAX_LAT) @(posedge clk);
    if (pending_results.size() != 0)
      flag_mismatch($sformatf("%0d results never arrived", pending_results.size()));

    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
